// ----- sv/dq_pkg.sv -----
// package: deque operation codes, widths, defaults and controller command type
`default_nettype none
package dq_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 16;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;
    localparam int OCC_W   = 11;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } dq_cmd_t;

endpackage
`default_nettype wire

// ----- sv/dq_ctrl.sv -----
// controller: sequences one item through load, execute and result cycles
`default_nettype none
module dq_ctrl
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    output dq_pkg::dq_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule
`default_nettype wire

// ----- sv/dq_datapath.sv -----
// datapath: ring buffer memory, head and tail indices, entry count, result fields
`default_nettype none
module dq_datapath
#(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dq_pkg::dq_cmd_t             cmd,
    input  wire logic [dq_pkg::OP_W-1:0]     operation,
    input  wire logic [dq_pkg::VALUE_W-1:0]  value,
    output logic [dq_pkg::VALUE_W-1:0]       popped_value,
    output logic                             underflow,
    output logic                             overflow,
    output logic [dq_pkg::OCC_W-1:0]         occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = dq_pkg::VALUE_W;
    localparam int OW = dq_pkg::OCC_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [dq_pkg::OP_W-1:0] op_reg;
    logic [VW-1:0]           value_reg;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    under_reg, under_next;
    logic                    over_reg, over_next;
    logic                    hit_reg, hit_next;
    logic [DATA_WIDTH-1:0]   rd_data_reg;

    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           mem_addr;
    logic [AW-1:0]           head_inc, head_dec, tail_inc, tail_dec;
    logic                    full, empty;
    logic [DATA_WIDTH+VW-1:0] wr_ext;
    logic [DATA_WIDTH+VW-1:0] rd_ext;
    logic [CW+OW-1:0]         cnt_ext;

    assign wr_ext  = {{DATA_WIDTH{1'b0}}, value_reg};
    assign rd_ext  = {{VW{1'b0}}, rd_data_reg};
    assign cnt_ext = {{OW{1'b0}}, count_reg};

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        under_next = under_reg;
        over_next  = over_reg;
        hit_next   = hit_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = head_reg;
        if (cmd.exec)
        begin
            under_next = 1'b0;
            over_next  = 1'b0;
            hit_next   = 1'b0;
            unique case (op_reg)
                dq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        over_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        mem_addr   = head_dec;
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                dq_pkg::OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        over_next = 1'b1;
                    end
                    else
                    begin
                        tail_next  = tail_inc;
                        mem_addr   = tail_reg;
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                dq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        mem_addr   = head_reg;
                        mem_re     = 1'b1;
                        hit_next   = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                dq_pkg::OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        mem_addr   = tail_dec;
                        mem_re     = 1'b1;
                        hit_next   = 1'b1;
                        tail_next  = tail_dec;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wr_ext[DATA_WIDTH-1:0];
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            under_reg <= 1'b0;
            over_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            under_reg <= under_next;
            over_reg  <= over_next;
            hit_reg   <= hit_next;
        end
    end

    assign popped_value = hit_reg ? rd_ext[VW-1:0] : '0;
    assign underflow    = under_reg;
    assign overflow     = over_reg;
    assign occupancy    = cnt_ext[OW-1:0];

endmodule
`default_nettype wire

// ----- sv/double_ended_queue_top.sv -----
// top level: double-ended queue on a ring buffer, controller plus datapath
//
//   channel   handshake          fields
//   command   start / busy       operation, value
//   result    done (strobe)      popped_value, underflow, overflow, occupancy
//
// an item passes through accept, execute (at most one memory write or read), result
// the single-port ring buffer memory is touched at most once per item, in the execute cycle
// busy stays high from the cycle after accept through the result cycle
// done is high for one cycle; the result must be taken then
// after reset the queue is empty; memory contents are undefined until pushed
`default_nettype none
module double_ended_queue_top
#(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [dq_pkg::OP_W-1:0]     operation,
    input  wire logic [dq_pkg::VALUE_W-1:0]  value,
    output logic                             done,
    output logic [dq_pkg::VALUE_W-1:0]       popped_value,
    output logic                             underflow,
    output logic                             overflow,
    output logic [dq_pkg::OCC_W-1:0]         occupancy
);

    dq_pkg::dq_cmd_t cmd;

    dq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    dq_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .value        (value),
        .popped_value (popped_value),
        .underflow    (underflow),
        .overflow     (overflow),
        .occupancy    (occupancy)
    );

endmodule
`default_nettype wire
